@@ rtl/stereo_sfx_upsample_mix_clamp_unit_assert.svh @@
// Assertion macros for the stereo effects upsample, mix and clamp unit.
`ifndef STEREO_SFX_UPSAMPLE_MIX_CLAMP_UNIT_ASSERT_SVH
`define STEREO_SFX_UPSAMPLE_MIX_CLAMP_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSUMC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stereo sfx unit: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SSUMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stereo sfx unit: check failed");

`endif

@@ rtl/ssumc_pkg.sv @@
// Types and constants for the stereo effects upsample, mix and clamp unit.
package ssumc_pkg;

    localparam int BG_W      = 16;
    localparam int FX_W      = 18;
    localparam int RUN_W     = 19;
    localparam int MIX_W     = 17;
    localparam int OUT_W     = 16;
    localparam int VOL_W     = 15;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(VOL_W - 1);

    localparam logic [IDX_W-1:0] REG_FX_VOL     = 2'd0;
    localparam logic [IDX_W-1:0] REG_MASTER_VOL = 2'd1;
    localparam logic [IDX_W-1:0] REG_UOFFSET    = 2'd2;

    localparam logic [VOL_W-1:0] FX_VOL_RST     = 15'd22937;
    localparam logic [VOL_W-1:0] MASTER_VOL_RST = 15'd32767;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_INTERP,
        ST_MIX_LOAD,
        ST_MIX,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic run;
    } mul_ctl_t;

endpackage

@@ rtl/stereo_sfx_upsample_mix_clamp_unit.sv @@
// Top level: stereo effects upsampler, mixer, clamp and output scaler.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   bg_left, bg_right, fx_left, fx_right
//  m_*      out  m_tvalid/m_tready   out_left, out_right
//  cfg_*    in   cfg_valid/cfg_ready index + 15-bit data
//
// Frames at group phase 1..3 go straight to the mix pass (MIX_LOAD, MIX, OUT); the phase 0
// frame runs the effects scaling (SCALE, INTERP) first. Both passes are bit-serial
// multiplies, one volume bit per cycle, left and right in parallel.
// s_tready is high only when idle; a finished item waits in the output register
// while the next item is taken. Reset clears control and ramp state, presets the settings.
`include "stereo_sfx_upsample_mix_clamp_unit_assert.svh"
module stereo_sfx_upsample_mix_clamp_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // bg_left[15:0], bg_right[31:16], fx_left[49:32], fx_right[67:50], zeros above
    input  logic [ssumc_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_left[15:0], out_right[31:16]
    output logic [ssumc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ssumc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [ssumc_pkg::VOL_W-1:0]          cfg_data
);
    import ssumc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [1:0] phase_reg;

    logic [VOL_W-1:0] fx_vol_reg;
    logic [VOL_W-1:0] master_vol_reg;
    logic             uoffset_reg;

    logic signed [FX_W-1:0]  held_l_reg, held_r_reg;
    logic signed [RUN_W-1:0] run_l_reg, run_r_reg, run_l_next, run_r_next;
    logic signed [RUN_W-1:0] step_l_reg, step_r_reg, step_l_next, step_r_next;
    logic signed [BG_W-1:0]  bg_l_reg, bg_r_reg;
    logic [OUT_W-1:0]        out_l_reg, out_r_reg;
    logic                    out_valid_reg;

    logic accept;
    logic out_load;
    mul_ctl_t scale_ctl;
    mul_ctl_t mix_ctl;

    logic signed [FX_W-1:0]  fx_l_in, fx_r_in;
    logic signed [FX_W-1:0]  sh_l, sh_r, sn_l, sn_r;
    logic signed [MIX_W-1:0] mix_in_l, mix_in_r, mix_out_l, mix_out_r;
    logic signed [RUN_W-1:0] diff_l, diff_r;

    assign fx_l_in = s_tdata[2*BG_W +: FX_W];
    assign fx_r_in = s_tdata[2*BG_W+FX_W +: FX_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (phase_reg == 2'd0) ? ST_SCALE : ST_MIX_LOAD;
                end
            end
            ST_SCALE:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_INTERP;
                end
            end
            ST_INTERP:   state_next = ST_MIX_LOAD;
            ST_MIX_LOAD: state_next = ST_MIX;
            ST_MIX:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        accept        = s_tvalid && s_tready;
        scale_ctl.load = accept && (phase_reg == 2'd0);
        scale_ctl.run  = (state_reg == ST_SCALE);
        mix_ctl.load   = (state_reg == ST_MIX_LOAD);
        mix_ctl.run    = (state_reg == ST_MIX);
        out_load       = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
        if ((state_reg == ST_SCALE || state_reg == ST_MIX) && cnt_reg != MUL_LAST)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = '0;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_r_reg, out_l_reg};

    ssumc_mul #(.W(FX_W)) u_held_l (
        .clk (clk), .ctl (scale_ctl), .mand (held_l_reg), .mult (fx_vol_reg), .prod (sh_l)
    );
    ssumc_mul #(.W(FX_W)) u_held_r (
        .clk (clk), .ctl (scale_ctl), .mand (held_r_reg), .mult (fx_vol_reg), .prod (sh_r)
    );
    ssumc_mul #(.W(FX_W)) u_new_l (
        .clk (clk), .ctl (scale_ctl), .mand (fx_l_in), .mult (fx_vol_reg), .prod (sn_l)
    );
    ssumc_mul #(.W(FX_W)) u_new_r (
        .clk (clk), .ctl (scale_ctl), .mand (fx_r_in), .mult (fx_vol_reg), .prod (sn_r)
    );
    ssumc_mul #(.W(MIX_W)) u_mix_l (
        .clk (clk), .ctl (mix_ctl), .mand (mix_in_l), .mult (master_vol_reg), .prod (mix_out_l)
    );
    ssumc_mul #(.W(MIX_W)) u_mix_r (
        .clk (clk), .ctl (mix_ctl), .mand (mix_in_r), .mult (master_vol_reg), .prod (mix_out_r)
    );

    function automatic logic signed [MIX_W-1:0] clamp_offset(
        input logic signed [BG_W-1:0]  bg,
        input logic signed [RUN_W-1:0] fx,
        input logic                    uoff
    );
        logic signed [RUN_W:0]  sum;
        logic signed [BG_W-1:0] clamped;
        sum = (RUN_W+1)'(bg) + (RUN_W+1)'(fx);
        if (sum > (RUN_W+1)'(32767))
        begin
            clamped = 16'sh7FFF;
        end
        else if (sum < -(RUN_W+1)'(32768))
        begin
            clamped = 16'sh8000;
        end
        else
        begin
            clamped = sum[BG_W-1:0];
        end
        return {clamped[BG_W-1], clamped} + {1'b0, uoff, {(BG_W-1){1'b0}}};
    endfunction

    assign mix_in_l = clamp_offset(bg_l_reg, run_l_reg, uoffset_reg);
    assign mix_in_r = clamp_offset(bg_r_reg, run_r_reg, uoffset_reg);

    // interpolation datapath
    always_comb
    begin
        diff_l      = RUN_W'(sn_l) - RUN_W'(sh_l);
        diff_r      = RUN_W'(sn_r) - RUN_W'(sh_r);
        run_l_next  = run_l_reg;
        run_r_next  = run_r_reg;
        step_l_next = step_l_reg;
        step_r_next = step_r_reg;
        if (accept && phase_reg != 2'd0)
        begin
            run_l_next = run_l_reg + step_l_reg;
            run_r_next = run_r_reg + step_r_reg;
        end
        else if (state_reg == ST_INTERP)
        begin
            run_l_next  = RUN_W'(sh_l);
            run_r_next  = RUN_W'(sh_r);
            step_l_next = diff_l >>> 2;
            step_r_next = diff_r >>> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
            fx_vol_reg     <= FX_VOL_RST;
            master_vol_reg <= MASTER_VOL_RST;
            uoffset_reg    <= 1'b1;
            held_l_reg     <= '0;
            held_r_reg     <= '0;
            run_l_reg      <= '0;
            run_r_reg      <= '0;
            step_l_reg     <= '0;
            step_r_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            run_l_reg  <= run_l_next;
            run_r_reg  <= run_r_next;
            step_l_reg <= step_l_next;
            step_r_reg <= step_r_next;
            if (scale_ctl.load)
            begin
                held_l_reg <= fx_l_in;
                held_r_reg <= fx_r_in;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_reg + 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FX_VOL:     fx_vol_reg     <= cfg_data;
                    REG_MASTER_VOL: master_vol_reg <= cfg_data;
                    REG_UOFFSET:    uoffset_reg    <= cfg_data[0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bg_l_reg <= s_tdata[0 +: BG_W];
            bg_r_reg <= s_tdata[BG_W +: BG_W];
        end
        if (out_load)
        begin
            out_l_reg <= mix_out_l[OUT_W-1:0];
            out_r_reg <= mix_out_r[OUT_W-1:0];
        end
    end

    `SSUMC_ASSERT_NEXT(a_phase0_scales, accept && phase_reg == 2'd0, state_reg == ST_SCALE)
    `SSUMC_ASSERT_NEXT(a_other_mixes, accept && phase_reg != 2'd0, state_reg == ST_MIX_LOAD)
    `SSUMC_ASSERT_NEXT(a_scale_len, state_reg == ST_SCALE && cnt_reg == MUL_LAST, state_reg == ST_INTERP)
    `SSUMC_ASSERT_NEXT(a_phase_step, out_load, phase_reg == $past(phase_reg) + 2'd1 && m_tvalid)

endmodule

@@ rtl/ssumc_mul.sv @@
// Bit-serial signed by unsigned Q15 multiplier, result floored by 2^15.
module ssumc_mul #(
    parameter int W = 18
) (
    input  logic                      clk,
    input  ssumc_pkg::mul_ctl_t       ctl,
    input  logic signed [W-1:0]       mand,
    input  logic [ssumc_pkg::VOL_W-1:0] mult,
    output logic signed [W-1:0]       prod
);
    import ssumc_pkg::*;

    logic signed [W-1:0] acc_reg;
    logic signed [W-1:0] acc_next;
    logic signed [W-1:0] mand_reg;
    logic [VOL_W-1:0]    mult_reg;
    logic [VOL_W-1:0]    mult_next;
    logic signed [W:0]   sum;

    // one multiplier bit a cycle, LSB first; acc is the running floor of the product
    always_comb
    begin
        sum       = {acc_reg[W-1], acc_reg} + (mult_reg[0] ? {mand_reg[W-1], mand_reg} : '0);
        acc_next  = acc_reg;
        mult_next = mult_reg;
        if (ctl.load)
        begin
            acc_next  = '0;
            mult_next = mult;
        end
        else if (ctl.run)
        begin
            acc_next  = sum[W:1];
            mult_next = {1'b0, mult_reg[VOL_W-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        mult_reg <= mult_next;
        if (ctl.load)
        begin
            mand_reg <= mand;
        end
    end

    assign prod = acc_reg;

endmodule

@@ tb/stereo_sfx_upsample_mix_clamp_unit_tb.sv @@
// Self-checking testbench for the stereo effects upsample, mix and clamp unit.
module stereo_sfx_upsample_mix_clamp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssumc_pkg::*;

    localparam int LIMIT_CYCLES     = 1_000_000;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int ITEMS_PER_PHASE  = 305;
    localparam int RANDOM_PHASES    = 6;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic signed [BG_W-1:0] bg_l;
        logic signed [BG_W-1:0] bg_r;
        logic signed [FX_W-1:0] fx_l;
        logic signed [FX_W-1:0] fx_r;
    } frame_t;

    typedef struct {
        logic [OUT_W-1:0] out_l;
        logic [OUT_W-1:0] out_r;
    } word_pair_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [VOL_W-1:0]       cfg_data = '0;

    // local copy of the unit's registers and interpolation state
    logic [VOL_W-1:0]       fx_gain = FX_VOL_RST;
    logic [VOL_W-1:0]       out_gain = MASTER_VOL_RST;
    logic                   add_offset = 1'b1;
    logic [1:0]             phase_ctr = '0;
    logic signed [FX_W-1:0] held_l = '0;
    logic signed [FX_W-1:0] held_r = '0;
    logic signed [RUN_W-1:0] ramp_l = '0;
    logic signed [RUN_W-1:0] ramp_r = '0;
    logic signed [RUN_W-1:0] ramp_step_l = '0;
    logic signed [RUN_W-1:0] ramp_step_r = '0;

    frame_t     pending_frames[$];
    word_pair_t expected_words[$];
    frame_t     offered_frame;
    bit         holding = 1'b0;
    int         burst_left = 1;
    int         gap_left = 0;
    bit         long_hold_req = 1'b0;
    int         hold_cycles = 0;
    int         rx_mode = 0;
    int         rx_mode_left = 0;
    int         rx_tick = 0;
    int         cycle_count = 0;
    int         error_count = 0;

    stereo_sfx_upsample_mix_clamp_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic longint scale_effect(logic signed [FX_W-1:0] s);
        return (longint'(fx_gain) * longint'(s)) >>> 15;
    endfunction

    function automatic logic [OUT_W-1:0] mix_sample(longint bg, longint fx);
        longint sum;
        longint scaled;
        sum = bg + fx;
        if (sum > 32767)
            sum = 32767;
        if (sum < -32768)
            sum = -32768;
        if (add_offset)
            sum = sum + 32768;
        scaled = (longint'(out_gain) * sum) >>> 15;
        return scaled[OUT_W-1:0];
    endfunction

    function automatic word_pair_t compute_mixed_words(frame_t f);
        word_pair_t w;
        longint     target_l;
        longint     target_r;
        if (phase_ctr == 2'd0)
        begin
            ramp_l = RUN_W'(scale_effect(held_l));
            ramp_r = RUN_W'(scale_effect(held_r));
            target_l = scale_effect(f.fx_l);
            target_r = scale_effect(f.fx_r);
            ramp_step_l = RUN_W'((target_l - longint'(ramp_l)) >>> 2);
            ramp_step_r = RUN_W'((target_r - longint'(ramp_r)) >>> 2);
            held_l = f.fx_l;
            held_r = f.fx_r;
        end
        else
        begin
            ramp_l = ramp_l + ramp_step_l;
            ramp_r = ramp_r + ramp_step_r;
        end
        w.out_l = mix_sample(longint'(f.bg_l), longint'(ramp_l));
        w.out_r = mix_sample(longint'(f.bg_r), longint'(ramp_r));
        phase_ctr = phase_ctr + 2'd1;
        return w;
    endfunction

    function automatic void queue_frame(longint bl, longint br, longint fl, longint fr);
        frame_t f;
        f.bg_l = BG_W'(bl);
        f.bg_r = BG_W'(br);
        f.fx_l = FX_W'(fl);
        f.fx_r = FX_W'(fr);
        pending_frames.push_back(f);
    endfunction

    function automatic longint random_sample(int w);
        longint lo;
        longint hi;
        lo = -(longint'(1) << (w - 1));
        hi = (longint'(1) << (w - 1)) - 1;
        case ($urandom_range(0, 9))
            0: return lo;
            1: return hi;
            2: return longint'($urandom_range(0, 512)) - 256;
            default: return longint'($urandom_range(0, (1 << w) - 1)) + lo;
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VOL_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_FX_VOL:     fx_gain = val;
            REG_MASTER_VOL: out_gain = val;
            REG_UOFFSET:    add_offset = val[0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_frames.size() != 0 || holding || expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender: bursts of items separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && !holding)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_frames.size() != 0)
            begin
                offered_frame = pending_frames.pop_front();
                s_tdata  <= IN_TDATA_W'({offered_frame.fx_r, offered_frame.fx_l,
                                         offered_frame.bg_r, offered_frame.bg_l});
                s_tvalid <= 1'b1;
                holding = 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_words.push_back(compute_mixed_words(offered_frame));
            holding = 1'b0;
        end
    end

    // receiver: stall pattern is re-drawn at random, plus long holds on request
    always @(negedge clk)
    begin
        rx_tick++;
        if (long_hold_req)
        begin
            hold_cycles = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left <= 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_tick % 7) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        word_pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected output item %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata[15:0] !== want.out_l)
                begin
                    $display("%0t: out_left expected %h, got %h", $time, want.out_l,
                             m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[31:16] !== want.out_r)
                begin
                    $display("%0t: out_right expected %h, got %h", $time, want.out_r,
                             m_tdata[31:16]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** stereo_sfx_upsample_mix_clamp_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int i;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes and a full-scale swing of the effects ramp
        queue_frame(32767, -32768, 131071, -131072);
        queue_frame(-32768, 32767, -131072, 131071);
        queue_frame(0, -1, 5, -5);
        queue_frame(1, 0, 131071, 131071);
        queue_frame(-32768, 32767, -131072, 131071);
        queue_frame(32767, -32768, 0, 0);
        queue_frame(-1, -1, 0, 0);
        queue_frame(32767, 32767, 0, 0);
        queue_frame(0, 0, 0, 0);
        queue_frame(-32768, -32768, 77, -77);
        queue_frame(12345, -12345, -1, 1);
        queue_frame(-2, 2, 131071, -131072);
        wait_idle();

        // full gains, offset cleared through a masked write, stray index ignored
        write_reg(REG_FX_VOL, 15'h7FFF);
        write_reg(REG_MASTER_VOL, 15'h7FFF);
        write_reg(REG_UOFFSET, 15'h7FFE);
        write_reg(REG_UNUSED, 15'h1234);
        queue_frame(-32768, -32768, -3, 3);
        queue_frame(-1, -32768, 99, -99);
        queue_frame(-20000, 20000, 0, 0);
        queue_frame(32767, -32768, 0, 0);
        queue_frame(-32768, 32767, 131071, -131072);
        queue_frame(-100, 100, 0, 0);
        queue_frame(0, 0, 0, 0);
        queue_frame(32767, 32767, 0, 0);
        queue_frame(0, 0, -131072, 131071);
        queue_frame(-1, 1, 0, 0);
        queue_frame(-32768, 32767, 0, 0);
        queue_frame(1, -1, 0, 0);
        wait_idle();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_FX_VOL, 15'd0);
                    write_reg(REG_MASTER_VOL, 15'h7FFF);
                    write_reg(REG_UOFFSET, 15'd0);
                end
                1:
                begin
                    write_reg(REG_FX_VOL, 15'h7FFF);
                    write_reg(REG_MASTER_VOL, 15'd0);
                    write_reg(REG_UOFFSET, 15'd1);
                end
                2:
                begin
                    write_reg(REG_FX_VOL, 15'h7FFF);
                    write_reg(REG_MASTER_VOL, 15'h7FFF);
                    write_reg(REG_UOFFSET, 15'h7FFF);
                end
                default:
                begin
                    write_reg(REG_FX_VOL, VOL_W'($urandom_range(0, 32767)));
                    write_reg(REG_UNUSED, VOL_W'($urandom_range(0, 32767)));
                    write_reg(REG_MASTER_VOL, VOL_W'($urandom_range(0, 32767)));
                    write_reg(REG_UOFFSET, VOL_W'($urandom_range(0, 32767)));
                end
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                queue_frame(random_sample(BG_W), random_sample(BG_W),
                            random_sample(FX_W), random_sample(FX_W));
            if (ph == 2 || ph == 4)
                long_hold_req = 1'b1;
            wait_idle();
        end

        if (error_count == 0)
            $display("** stereo_sfx_upsample_mix_clamp_unit: PASSED **");
        else
            $display("** stereo_sfx_upsample_mix_clamp_unit: FAILED **");
        $finish;
    end

endmodule
